// File: rtl/pba_pkg.sv
// Package for the page block allocator: sizes, codes, item and table types.
// Has no dependencies; every rtl module imports it.
`default_nettype none

package pba_pkg;

    localparam int PAGE_BYTES = 1024;
    localparam int POOL_PAGES = 64;

    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int SIZE_W     = 20;
    localparam int PG_W       = $clog2(POOL_PAGES);
    localparam int CNT_W      = $clog2(POOL_PAGES + 1);
    localparam int NEED_W     = SIZE_W - PAGE_SHIFT + 1;
    localparam int OP_W       = (NEED_W > CNT_W) ? NEED_W : CNT_W;

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_REALLOC = 2'd1,
        CMD_FREE    = 2'd2,
        CMD_RSVD    = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_OOM       = 3'd1,
        ST_UNKNOWN   = 3'd2,
        ST_LIST_FULL = 3'd3,
        ST_ZERO      = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_CARVE,
        S_GRANT,
        S_RELEASE,
        S_FINISH
    } state_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [PG_W-1:0]   block_start;
        logic [SIZE_W-1:0] size_bytes;
    } req_t;

    typedef struct packed {
        status_t          status;
        logic [PG_W-1:0]  result_start;
        logic [CNT_W-1:0] result_pages;
        logic             copy_needed;
        logic [PG_W-1:0]  copy_from_start;
        logic [CNT_W-1:0] copy_pages;
    } rsp_t;

    typedef struct packed {
        logic [PG_W-1:0]  start;
        logic [CNT_W-1:0] pages;
    } span_t;

    typedef struct packed {
        logic            wr_en;
        logic [PG_W-1:0] addr;
        span_t           data;
    } fl_wr_t;

    typedef struct packed {
        logic             wr_en;
        logic             valid;
        logic [PG_W-1:0]  addr;
        logic [CNT_W-1:0] pages;
    } bt_wr_t;

endpackage

`default_nettype wire

// File: rtl/pba_alu.sv
// Shared compare unit of the allocator: a subtractor that reports a >= b.
// Depends on pba_pkg.
`default_nettype none

module pba_alu (
    input  wire logic [pba_pkg::OP_W-1:0] a,
    input  wire logic [pba_pkg::OP_W-1:0] b,
    output logic                          ge
);
    import pba_pkg::*;

    logic [OP_W:0] diff;

    assign diff = {1'b0, a} - {1'b0, b};
    assign ge   = ~diff[OP_W];

endmodule

`default_nettype wire

// File: rtl/pba_flist.sv
// Free-list memory: one write port and one read port with registered data.
// Depends on pba_pkg.
`default_nettype none

module pba_flist (
    input  wire logic                     clk,
    input  wire pba_pkg::fl_wr_t          wr,
    input  wire logic [pba_pkg::PG_W-1:0] raddr,
    output pba_pkg::span_t                rdata
);
    import pba_pkg::*;

    span_t mem [POOL_PAGES];
    span_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.wr_en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/pba_btable.sv
// Block table: a live bit per start page in flip-flops and a page-count memory.
// Depends on pba_pkg.
`default_nettype none

module pba_btable (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire pba_pkg::bt_wr_t           wr,
    input  wire logic [pba_pkg::PG_W-1:0]  raddr,
    output logic                           rvalid,
    output logic [pba_pkg::CNT_W-1:0]      rpages
);
    import pba_pkg::*;

    logic             valid_reg [POOL_PAGES];
    logic [CNT_W-1:0] pages_mem [POOL_PAGES];
    logic             rvalid_reg;
    logic [CNT_W-1:0] rpages_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < POOL_PAGES; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (wr.wr_en)
        begin
            valid_reg[wr.addr] <= wr.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.wr_en)
        begin
            pages_mem[wr.addr] <= wr.pages;
        end
        rvalid_reg <= valid_reg[raddr];
        rpages_reg <= pages_mem[raddr];
    end

    assign rvalid = rvalid_reg;
    assign rpages = rpages_reg;

endmodule

`default_nettype wire

// File: rtl/pba_ctrl.sv
// Sequencer of the allocator: decode, first-fit scan, close-up, carve and release.
// Depends on pba_pkg; drives pba_alu, pba_flist and pba_btable.
`default_nettype none

module pba_ctrl (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      req_valid,
    input  wire pba_pkg::req_t             req,
    output logic                           busy,
    output logic [pba_pkg::PG_W-1:0]       bt_raddr,
    input  wire logic                      bt_rvalid,
    input  wire logic [pba_pkg::CNT_W-1:0] bt_rpages,
    output pba_pkg::bt_wr_t                bt_wr,
    output logic [pba_pkg::PG_W-1:0]       fl_raddr,
    input  wire pba_pkg::span_t            fl_rdata,
    output pba_pkg::fl_wr_t                fl_wr,
    output logic [pba_pkg::OP_W-1:0]       alu_a,
    output logic [pba_pkg::OP_W-1:0]       alu_b,
    input  wire logic                      alu_ge,
    input  wire logic                      rsp_free,
    output logic                           rsp_load,
    output pba_pkg::rsp_t                  rsp_data
);
    import pba_pkg::*;

    state_t            state_reg,      state_next;
    cmd_t              cmd_reg,        cmd_next;
    logic [PG_W-1:0]   bstart_reg,     bstart_next;
    logic [NEED_W-1:0] need_reg,       need_next;
    logic [CNT_W-1:0]  old_reg,        old_next;
    logic [CNT_W-1:0]  idx_reg,        idx_next;
    span_t             got_reg,        got_next;
    logic [CNT_W-1:0]  free_count_reg, free_count_next;
    logic [CNT_W-1:0]  carve_top_reg,  carve_top_next;
    rsp_t              res_reg,        res_next;

    logic              size_zero;
    logic [CNT_W-1:0]  idx_inc;
    logic              list_full;

    assign idx_inc   = idx_reg + CNT_W'(1);
    assign list_full = (free_count_reg == CNT_W'(POOL_PAGES));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            free_count_reg <= '0;
            carve_top_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            free_count_reg <= free_count_next;
            carve_top_reg  <= carve_top_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        bstart_reg <= bstart_next;
        need_reg   <= need_next;
        old_reg    <= old_next;
        idx_reg    <= idx_next;
        got_reg    <= got_next;
        res_reg    <= res_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        bstart_next     = bstart_reg;
        need_next       = need_reg;
        old_next        = old_reg;
        idx_next        = idx_reg;
        got_next        = got_reg;
        free_count_next = free_count_reg;
        carve_top_next  = carve_top_reg;
        res_next        = res_reg;
        size_zero       = (req.size_bytes == '0);
        busy            = 1'b1;
        bt_raddr        = bstart_reg;
        bt_wr           = '0;
        fl_raddr        = idx_reg[PG_W-1:0];
        fl_wr           = '0;
        alu_a           = '0;
        alu_b           = '0;
        rsp_load        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                busy     = 1'b0;
                bt_raddr = req.block_start;
                if (req_valid)
                begin
                    cmd_next    = req.cmd;
                    bstart_next = req.block_start;
                    need_next   = NEED_W'(req.size_bytes >> PAGE_SHIFT)
                                + NEED_W'(|req.size_bytes[PAGE_SHIFT-1:0]);
                    old_next    = '0;
                    idx_next    = '0;
                    res_next    = '0;
                    res_next.status = size_zero ? ST_ZERO : ST_OK;
                    state_next  = S_DECODE;
                end
            end

            S_DECODE:
            begin
                alu_a = OP_W'(bt_rpages);
                alu_b = OP_W'(need_reg);
                state_next = S_FINISH;
                unique case (cmd_reg)
                    CMD_ALLOC:
                    begin
                        if (res_reg.status != ST_ZERO)
                        begin
                            state_next = S_SCAN_RD;
                        end
                    end
                    CMD_REALLOC:
                    begin
                        if (res_reg.status == ST_ZERO)
                        begin
                            state_next = S_FINISH;
                        end
                        else if (!bt_rvalid)
                        begin
                            res_next.status = ST_UNKNOWN;
                        end
                        else if (alu_ge)
                        begin
                            res_next.result_start = bstart_reg;
                            res_next.result_pages = bt_rpages;
                        end
                        else
                        begin
                            old_next   = bt_rpages;
                            state_next = S_SCAN_RD;
                        end
                    end
                    CMD_FREE:
                    begin
                        res_next.status = ST_OK;
                        if (!bt_rvalid)
                        begin
                            res_next.status = ST_UNKNOWN;
                        end
                        else if (list_full)
                        begin
                            res_next.status = ST_LIST_FULL;
                        end
                        else
                        begin
                            fl_wr.wr_en      = 1'b1;
                            fl_wr.addr       = free_count_reg[PG_W-1:0];
                            fl_wr.data.start = bstart_reg;
                            fl_wr.data.pages = bt_rpages;
                            free_count_next  = free_count_reg + CNT_W'(1);
                            bt_wr.wr_en      = 1'b1;
                            bt_wr.valid      = 1'b0;
                            bt_wr.addr       = bstart_reg;
                            bt_wr.pages      = bt_rpages;
                            res_next.result_start = bstart_reg;
                            res_next.result_pages = bt_rpages;
                        end
                    end
                    default:
                    begin
                        res_next.status = ST_UNKNOWN;
                    end
                endcase
            end

            S_SCAN_RD:
            begin
                if (idx_reg == free_count_reg)
                begin
                    state_next = S_CARVE;
                end
                else
                begin
                    state_next = S_SCAN_CHK;
                end
            end

            S_SCAN_CHK:
            begin
                alu_a = OP_W'(fl_rdata.pages);
                alu_b = OP_W'(need_reg);
                if (alu_ge)
                begin
                    got_next   = fl_rdata;
                    state_next = S_SHIFT_RD;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = S_SCAN_RD;
                end
            end

            S_SHIFT_RD:
            begin
                alu_a    = OP_W'(idx_inc);
                alu_b    = OP_W'(free_count_reg);
                fl_raddr = idx_inc[PG_W-1:0];
                if (!alu_ge)
                begin
                    state_next = S_SHIFT_WR;
                end
                else
                begin
                    free_count_next = free_count_reg - CNT_W'(1);
                    state_next      = S_GRANT;
                end
            end

            S_SHIFT_WR:
            begin
                fl_wr.wr_en = 1'b1;
                fl_wr.addr  = idx_reg[PG_W-1:0];
                fl_wr.data  = fl_rdata;
                idx_next    = idx_inc;
                state_next  = S_SHIFT_RD;
            end

            S_CARVE:
            begin
                alu_a = OP_W'(POOL_PAGES) - OP_W'(carve_top_reg);
                alu_b = OP_W'(need_reg);
                state_next = S_FINISH;
                if (!alu_ge)
                begin
                    res_next.status = ST_OOM;
                end
                else if (cmd_reg == CMD_REALLOC && list_full)
                begin
                    res_next.status = ST_LIST_FULL;
                end
                else
                begin
                    got_next.start = carve_top_reg[PG_W-1:0];
                    got_next.pages = CNT_W'(need_reg);
                    carve_top_next = carve_top_reg + CNT_W'(need_reg);
                    state_next     = S_GRANT;
                end
            end

            S_GRANT:
            begin
                bt_wr.wr_en = 1'b1;
                bt_wr.valid = 1'b1;
                bt_wr.addr  = got_reg.start;
                bt_wr.pages = got_reg.pages;
                res_next.result_start = got_reg.start;
                res_next.result_pages = got_reg.pages;
                state_next = (cmd_reg == CMD_REALLOC) ? S_RELEASE : S_FINISH;
            end

            S_RELEASE:
            begin
                bt_wr.wr_en      = 1'b1;
                bt_wr.valid      = 1'b0;
                bt_wr.addr       = bstart_reg;
                bt_wr.pages      = old_reg;
                fl_wr.wr_en      = 1'b1;
                fl_wr.addr       = free_count_reg[PG_W-1:0];
                fl_wr.data.start = bstart_reg;
                fl_wr.data.pages = old_reg;
                free_count_next  = free_count_reg + CNT_W'(1);
                res_next.copy_needed     = 1'b1;
                res_next.copy_from_start = bstart_reg;
                res_next.copy_pages      = old_reg;
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                if (rsp_free)
                begin
                    rsp_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp_data = res_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_count_reg <= CNT_W'(POOL_PAGES))
        else $error("free list count beyond pool size");

    a_carve_bound: assert property (@(posedge clk) disable iff (!rst_n)
        carve_top_reg <= CNT_W'(POOL_PAGES))
        else $error("carve top beyond pool size");

    a_shift_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT_WR) |-> (idx_inc < free_count_reg))
        else $error("close-up write beyond the list");

    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && req_valid) |=> (state_reg == S_DECODE))
        else $error("accepted item not decoded");
`endif

endmodule

`default_nettype wire

// File: rtl/page_block_allocator.sv
// Top level of the page block allocator: sequencer, compare unit, tables, output register.
// Depends on pba_pkg, pba_alu, pba_flist, pba_btable and pba_ctrl.
//
//  channel | payload | handshake            | direction
//  req     | req_t   | req_valid, req_stall | into the block
//  rsp     | rsp_t   | rsp_valid, rsp_stall | out of the block
//
// An item that ends at decode passes S_DECODE and S_FINISH; an allocation or a growing
// reallocation also passes the scan, the close-up or S_CARVE, and S_GRANT on success.
// Scan and close-up read each entry through one read port, then check or move it.
// Reset clears the live bits, the free-list count and the carve top at once.
// req_stall is high while an item is in work; a waiting result is held in the output
// register, so the next item is taken while rsp_stall holds it.
`default_nettype none

module page_block_allocator (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire pba_pkg::req_t  req,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output pba_pkg::rsp_t       rsp
);
    import pba_pkg::*;

    logic             busy;
    logic [PG_W-1:0]  bt_raddr;
    logic             bt_rvalid;
    logic [CNT_W-1:0] bt_rpages;
    bt_wr_t           bt_wr;
    logic [PG_W-1:0]  fl_raddr;
    span_t            fl_rdata;
    fl_wr_t           fl_wr;
    logic [OP_W-1:0]  alu_a;
    logic [OP_W-1:0]  alu_b;
    logic             alu_ge;
    logic             rsp_free;
    logic             rsp_load;
    rsp_t             rsp_data;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             rsp_reg,       rsp_next;

    pba_alu u_alu (
        .a  (alu_a),
        .b  (alu_b),
        .ge (alu_ge)
    );

    pba_flist u_flist (
        .clk   (clk),
        .wr    (fl_wr),
        .raddr (fl_raddr),
        .rdata (fl_rdata)
    );

    pba_btable u_btable (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (bt_wr),
        .raddr  (bt_raddr),
        .rvalid (bt_rvalid),
        .rpages (bt_rpages)
    );

    pba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .busy      (busy),
        .bt_raddr  (bt_raddr),
        .bt_rvalid (bt_rvalid),
        .bt_rpages (bt_rpages),
        .bt_wr     (bt_wr),
        .fl_raddr  (fl_raddr),
        .fl_rdata  (fl_rdata),
        .fl_wr     (fl_wr),
        .alu_a     (alu_a),
        .alu_b     (alu_b),
        .alu_ge    (alu_ge),
        .rsp_free  (rsp_free),
        .rsp_load  (rsp_load),
        .rsp_data  (rsp_data)
    );

    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = busy;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = rsp_data;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// File: test/page_block_allocator_test.sv
// Self-checking testbench for page_block_allocator: a directed table, then random
// allocate, reallocate and free items checked against an in-bench first-fit model.
// Depends on pba_pkg and the page_block_allocator RTL.
`default_nettype none

module page_block_allocator_test;

    timeunit 1ns;
    timeprecision 1ps;

    import pba_pkg::*;

    localparam int RANDOM_ITEMS = 900;
    localparam int LONG_HOLD    = 600;
    localparam int TAIL_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef struct {
        req_t    item;
        bit      typed;
        rsp_t    answer;
    } table_row_t;

    logic  clk;
    logic  rst_n;
    logic  req_valid;
    logic  req_stall;
    req_t  req;
    logic  rsp_valid;
    logic  rsp_stall;
    rsp_t  rsp;

    rsp_t        pending_rsp[$];
    table_row_t  directed[$];
    int          errors = 0;
    bit          long_hold_req;

    int unsigned       carve_top;
    bit                live[POOL_PAGES];
    logic [CNT_W-1:0]  live_pages[POOL_PAGES];
    span_t             free_spans[$];

    page_block_allocator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic status_t take_span(int unsigned need, bit room, output span_t got);
        int fit;
        fit = -1;
        got = '0;
        for (int i = 0; i < free_spans.size(); i++)
        begin
            if (fit < 0 && 32'(free_spans[i].pages) >= need)
            begin
                fit = i;
            end
        end
        if (fit >= 0)
        begin
            got = free_spans[fit];
            free_spans.delete(fit);
        end
        else
        begin
            if (need > POOL_PAGES - carve_top)
            begin
                return ST_OOM;
            end
            if (!room)
            begin
                return ST_LIST_FULL;
            end
            got.start = PG_W'(carve_top);
            got.pages = CNT_W'(need);
            carve_top += need;
        end
        live[got.start] = 1'b1;
        live_pages[got.start] = got.pages;
        return ST_OK;
    endfunction

    function automatic rsp_t predict_response(req_t r);
        rsp_t              a;
        span_t             got;
        span_t             old_span;
        int unsigned       need;
        logic [CNT_W-1:0]  old;
        a = '0;
        need = (32'(r.size_bytes) + PAGE_BYTES - 1) / PAGE_BYTES;
        case (r.cmd)
            CMD_ALLOC:
            begin
                if (r.size_bytes == '0)
                begin
                    a.status = ST_ZERO;
                end
                else
                begin
                    a.status = take_span(need, 1'b1, got);
                    if (a.status == ST_OK)
                    begin
                        a.result_start = got.start;
                        a.result_pages = got.pages;
                    end
                end
            end
            CMD_REALLOC:
            begin
                if (r.size_bytes == '0)
                begin
                    a.status = ST_ZERO;
                end
                else if (!live[r.block_start])
                begin
                    a.status = ST_UNKNOWN;
                end
                else
                begin
                    old = live_pages[r.block_start];
                    if (32'(old) >= need)
                    begin
                        a.result_start = r.block_start;
                        a.result_pages = old;
                    end
                    else
                    begin
                        a.status = take_span(need, free_spans.size() < POOL_PAGES, got);
                        if (a.status == ST_OK)
                        begin
                            live[r.block_start] = 1'b0;
                            old_span.start = r.block_start;
                            old_span.pages = old;
                            free_spans.push_back(old_span);
                            a.result_start    = got.start;
                            a.result_pages    = got.pages;
                            a.copy_needed     = 1'b1;
                            a.copy_from_start = r.block_start;
                            a.copy_pages      = old;
                        end
                    end
                end
            end
            CMD_FREE:
            begin
                if (!live[r.block_start])
                begin
                    a.status = ST_UNKNOWN;
                end
                else if (free_spans.size() >= POOL_PAGES)
                begin
                    a.status = ST_LIST_FULL;
                end
                else
                begin
                    old_span.start = r.block_start;
                    old_span.pages = live_pages[r.block_start];
                    free_spans.push_back(old_span);
                    live[r.block_start] = 1'b0;
                    a.result_start = r.block_start;
                    a.result_pages = live_pages[r.block_start];
                end
            end
            default:
            begin
                a.status = ST_UNKNOWN;
            end
        endcase
        return a;
    endfunction

    function automatic void add_row(cmd_t c, int bs, int sz, bit typed = 1'b0,
                                    status_t st = ST_OK, int rs = 0, int rp = 0);
        table_row_t row;
        row.item.cmd          = c;
        row.item.block_start  = PG_W'(bs);
        row.item.size_bytes   = SIZE_W'(sz);
        row.typed             = typed;
        row.answer            = '0;
        row.answer.status     = st;
        row.answer.result_start = PG_W'(rs);
        row.answer.result_pages = CNT_W'(rp);
        directed.push_back(row);
    endfunction

    function automatic logic [SIZE_W-1:0] request_bytes();
        if ($urandom_range(9) < 9)
        begin
            return SIZE_W'(($urandom_range(4, 1) - 1) * PAGE_BYTES
                           + $urandom_range(PAGE_BYTES, 1));
        end
        return SIZE_W'($urandom_range(2 ** SIZE_W - 1, 1));
    endfunction

    function automatic req_t next_request();
        req_t         r;
        int unsigned  owned[$];
        int unsigned  pick;
        r = '0;
        for (int s = 0; s < POOL_PAGES; s++)
        begin
            if (live[s])
            begin
                owned.push_back(s);
            end
        end
        pick = $urandom_range(99);
        if (pick < 40)
        begin
            r.cmd = CMD_ALLOC;
            r.size_bytes = request_bytes();
        end
        else if (pick < 90 && owned.size() > 0)
        begin
            r.cmd = (pick < 65) ? CMD_REALLOC : CMD_FREE;
            r.block_start = PG_W'(owned[$urandom_range(owned.size() - 1)]);
            r.size_bytes = request_bytes();
        end
        else
        begin
            r.cmd = cmd_t'($urandom_range(3));
            r.block_start = PG_W'($urandom_range(POOL_PAGES - 1));
            r.size_bytes = ($urandom_range(2) == 0) ? '0
                                                    : SIZE_W'($urandom_range(2 ** SIZE_W - 1));
        end
        return r;
    endfunction

    function automatic int gap_cycles();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 55)
        begin
            return 0;
        end
        if (pick < 85)
        begin
            return $urandom_range(3, 1);
        end
        if (pick < 97)
        begin
            return $urandom_range(12, 4);
        end
        return $urandom_range(60, 20);
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin : response_check
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("response item with no expectation waiting");
                errors++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                check_field("status", want.status, rsp.status);
                check_field("result_start", want.result_start, rsp.result_start);
                check_field("result_pages", want.result_pages, rsp.result_pages);
                check_field("copy_needed", want.copy_needed, rsp.copy_needed);
                check_field("copy_from_start", want.copy_from_start, rsp.copy_from_start);
                check_field("copy_pages", want.copy_pages, rsp.copy_pages);
            end
        end
    end

    initial
    begin : receiver
        int run;
        int hold;
        bit held;
        rsp_stall = 1'b0;
        held = 1'b0;
        forever
        begin
            if (long_hold_req && !held)
            begin
                @(negedge clk);
                rsp_stall <= 1'b1;
                for (int k = 1; k < LONG_HOLD; k++)
                begin
                    @(negedge clk);
                end
                held = 1'b1;
            end
            run = ($urandom_range(99) < 85) ? $urandom_range(8, 1) : $urandom_range(150, 40);
            @(negedge clk);
            rsp_stall <= 1'b0;
            repeat (run - 1) @(negedge clk);
            hold = gap_cycles();
            if (hold > 0)
            begin
                @(negedge clk);
                rsp_stall <= 1'b1;
                repeat (hold - 1) @(negedge clk);
            end
        end
    end

    initial
    begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin : sender
        int          n_directed;
        int          total;
        int          gap;
        bit          drain;
        req_t        item;
        rsp_t        answer;
        table_row_t  row;

        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        long_hold_req = 1'b0;
        carve_top = 0;
        for (int s = 0; s < POOL_PAGES; s++)
        begin
            live[s] = 1'b0;
            live_pages[s] = '0;
        end

        add_row(CMD_ALLOC, 0, 1, 1'b1, ST_OK, 0, 1);
        add_row(CMD_ALLOC, 0, 0, 1'b1, ST_ZERO);
        add_row(CMD_ALLOC, 0, 20'hFFFFF, 1'b1, ST_OOM);
        add_row(CMD_RSVD, 63, 20'hFFFFF, 1'b1, ST_UNKNOWN);
        add_row(CMD_FREE, 63, 0, 1'b1, ST_UNKNOWN);
        add_row(CMD_REALLOC, 40, 0, 1'b1, ST_ZERO);
        add_row(CMD_REALLOC, 40, 100, 1'b1, ST_UNKNOWN);
        add_row(CMD_ALLOC, 0, 1025);
        add_row(CMD_ALLOC, 0, 1024);
        add_row(CMD_ALLOC, 0, 4096);
        add_row(CMD_REALLOC, 1, 2048);
        add_row(CMD_REALLOC, 3, 1);
        add_row(CMD_REALLOC, 0, 3000);
        add_row(CMD_FREE, 1, 0);
        add_row(CMD_FREE, 1, 0, 1'b1, ST_UNKNOWN);
        add_row(CMD_ALLOC, 0, 2000);
        add_row(CMD_FREE, 4, 0);
        add_row(CMD_REALLOC, 3, 3500);
        add_row(CMD_REALLOC, 8, 20'hFFFFF, 1'b1, ST_OOM);
        add_row(CMD_ALLOC, 63, 1);
        add_row(CMD_ALLOC, 0, 65536, 1'b1, ST_OOM);
        add_row(CMD_FREE, 0, 20'hFFFFF);
        add_row(CMD_FREE, 8, 0);
        add_row(CMD_REALLOC, 63, 20'hFFFFF, 1'b1, ST_UNKNOWN);

        n_directed = directed.size();
        total = n_directed + RANDOM_ITEMS;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int n = 0; n < total; n++)
        begin
            row.typed = 1'b0;
            if (n < n_directed)
            begin
                row = directed[n];
                item = row.item;
            end
            else
            begin
                item = next_request();
            end
            if (n == n_directed + 250)
            begin
                long_hold_req = 1'b1;
            end
            drain = (n == n_directed + 450);
            gap = (n >= n_directed + 600 && n < n_directed + 700) ? 0 : gap_cycles();
            if (drain && gap == 0)
            begin
                gap = 1;
            end
            if (gap > 0)
            begin
                @(negedge clk);
                req_valid <= 1'b0;
                repeat (gap) @(negedge clk);
                while (drain && pending_rsp.size() != 0)
                begin
                    @(negedge clk);
                end
            end
            else
            begin
                @(negedge clk);
            end
            req <= item;
            req_valid <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (req_stall !== 1'b0);
            answer = predict_response(item);
            pending_rsp.push_back(row.typed ? row.answer : answer);
        end

        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && pending_rsp.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: page_block_allocator.f
rtl/pba_pkg.sv
rtl/pba_alu.sv
rtl/pba_flist.sv
rtl/pba_btable.sv
rtl/pba_ctrl.sv
rtl/page_block_allocator.sv
test/page_block_allocator_test.sv
